### rtl/core/abe_pkg.sv
// Shared types and constants for the allocation bitmap engine.
// Used by abe_flags, allocation_bitmap_engine_core, bitmap_op_checker and testbench.
package abe_pkg;

    localparam int WORD_BITS  = 8;
    localparam int WORD_COUNT = 64;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BIT_SHIFT  = $clog2(WORD_BITS);
    localparam int INDEX_W    = 9;
    localparam int KIND_W     = 3;
    localparam int CFG_W      = 7;
    localparam int WIDX_W     = INDEX_W - BIT_SHIFT;

    localparam logic [KIND_W-1:0] KIND_TEST       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_ALL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FIND_CLEAR = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FIND_SET   = 3'd6;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WORD_AW-1:0]   waddr_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] bit_index;
    } abe_in_t;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               all_clear;
        logic               all_set;
        logic               out_of_range;
    } abe_out_t;

    typedef struct packed {
        logic   set_all;
        logic   clear_all;
        logic   word_wr;
        waddr_t addr;
        logic   full;
        logic   empty;
        logic   find_set;
    } flag_cmd_t;

    typedef struct packed {
        logic   hit;
        waddr_t hit_addr;
        logic   all_clear;
        logic   all_set;
        logic   ovr;
        logic   ovr_val;
    } flag_stat_t;

endpackage

### rtl/core/abe_word_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; no package dependency.
module abe_word_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/abe_flags.sv
// Per-word summary flags: bulk override, full and empty bits, lowest-match search.
// Depends on abe_pkg.
module abe_flags (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [abe_pkg::CFG_W-1:0] n_live,
    input  abe_pkg::waddr_t           rd_addr,
    input  abe_pkg::flag_cmd_t        cmd,
    output abe_pkg::flag_stat_t       stat
);

    localparam int N = abe_pkg::WORD_COUNT;

    logic [N-1:0] ovr_reg;
    logic [N-1:0] ovr_val_reg;
    logic [N-1:0] full_reg;
    logic [N-1:0] empty_reg;
    logic [N-1:0] act;
    logic [N-1:0] cand;
    logic [N-1:0] low;
    abe_pkg::waddr_t hit_addr;

    always_comb begin
        for (int w = 0; w < N; w++) begin
            act[w] = (32'(w) < 32'(n_live));
        end
        cand = act & (cmd.find_set ? ~empty_reg : ~full_reg);
        low  = cand & (~cand + N'(1));
        hit_addr = '0;
        for (int w = 0; w < N; w++) begin
            if (low[w]) begin
                hit_addr = hit_addr | abe_pkg::waddr_t'(w);
            end
        end
    end

    assign stat.hit       = |cand;
    assign stat.hit_addr  = hit_addr;
    assign stat.all_clear = &(empty_reg | ~act);
    assign stat.all_set   = &(full_reg | ~act);
    assign stat.ovr       = ovr_reg[rd_addr];
    assign stat.ovr_val   = ovr_val_reg[rd_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovr_reg     <= '1;
            ovr_val_reg <= '0;
            full_reg    <= '0;
            empty_reg   <= '1;
        end else begin
            for (int w = 0; w < N; w++) begin
                if (cmd.set_all && act[w]) begin
                    ovr_reg[w]     <= 1'b1;
                    ovr_val_reg[w] <= 1'b1;
                    full_reg[w]    <= 1'b1;
                    empty_reg[w]   <= 1'b0;
                end else if (cmd.clear_all && act[w]) begin
                    ovr_reg[w]     <= 1'b1;
                    ovr_val_reg[w] <= 1'b0;
                    full_reg[w]    <= 1'b0;
                    empty_reg[w]   <= 1'b1;
                end else if (cmd.word_wr && (cmd.addr == abe_pkg::waddr_t'(w))) begin
                    ovr_reg[w]   <= 1'b0;
                    full_reg[w]  <= cmd.full;
                    empty_reg[w] <= cmd.empty;
                end
            end
        end
    end

endmodule

### rtl/core/allocation_bitmap_engine_core.sv
// Allocation bitmap engine top level: operation sequencer, word RAM and summary flags.
// Depends on abe_pkg, abe_word_ram and abe_flags.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation (kind, bit_index) per transfer.
//   m_valid/m_ready/m_data return exactly one result per operation, in order.
//   cfg_wr_en/cfg_wr_data write the active word count; write it only when idle.
// Sequence:
//   An accepted operation moves through S_LOOK, S_READ and S_DONE before m_valid
//   rises: S_LOOK searches the per-word full/empty flags and issues the word RAM
//   read, S_READ takes the read data, modifies it and writes it back, and S_DONE,
//   once the output register is free, loads the result with the all-clear and
//   all-set summaries. One operation is in flight at a time: s_ready returns as
//   the result is loaded. Set all and clear all pass through the same states,
//   using per-word override flags instead of sweeping the RAM.
// Reset:
//   aresetn (synchronous, active low) marks every word as overridden to zero,
//   so the bitmap reads all clear at once; active count returns to 64.
// Stall:
//   The result waits in the output register while m_ready is low; s_ready stays
//   low only while an operation is in progress or its result cannot be stored.
module allocation_bitmap_engine_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  abe_pkg::abe_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output abe_pkg::abe_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [abe_pkg::CFG_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [abe_pkg::CFG_W-1:0]   active_reg;
    logic [abe_pkg::CFG_W-1:0]   n_live;
    logic [abe_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [abe_pkg::INDEX_W-1:0] idx_reg, idx_next;
    abe_pkg::waddr_t             addr_reg, addr_next;
    logic                        found_reg, found_next;
    logic                        oor_reg, oor_next;
    abe_pkg::abe_out_t           res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    abe_pkg::abe_out_t           m_data_reg, m_data_next;

    logic [abe_pkg::WIDX_W-1:0]    word_full;
    logic [abe_pkg::BIT_SHIFT-1:0] pos;
    logic                          is_bit_op;
    logic                          is_find;
    logic                          in_range;

    abe_pkg::word_t     ram_q;
    abe_pkg::word_t     cur_word;
    abe_pkg::word_t     new_word;
    abe_pkg::word_t     bit_mask;
    abe_pkg::word_t     scan_word;
    abe_pkg::word_t     scan_low;
    logic [abe_pkg::BIT_SHIFT-1:0] scan_pos;
    logic               ram_we;
    logic               ram_re;

    abe_pkg::flag_cmd_t  fcmd;
    abe_pkg::flag_stat_t fstat;

    assign n_live = (32'(active_reg) > 32'(abe_pkg::WORD_COUNT))
                  ? abe_pkg::CFG_W'(abe_pkg::WORD_COUNT) : active_reg;

    assign word_full = idx_reg[abe_pkg::INDEX_W-1:abe_pkg::BIT_SHIFT];
    assign pos       = idx_reg[abe_pkg::BIT_SHIFT-1:0];
    assign is_bit_op = (kind_reg == abe_pkg::KIND_TEST) || (kind_reg == abe_pkg::KIND_SET)
                    || (kind_reg == abe_pkg::KIND_CLEAR);
    assign is_find   = (kind_reg == abe_pkg::KIND_FIND_CLEAR)
                    || (kind_reg == abe_pkg::KIND_FIND_SET);
    assign in_range  = (32'(word_full) < 32'(n_live));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cur_word  = fstat.ovr ? {abe_pkg::WORD_BITS{fstat.ovr_val}} : ram_q;
    assign bit_mask  = abe_pkg::word_t'(1) << pos;
    assign new_word  = (kind_reg == abe_pkg::KIND_SET) ? (cur_word | bit_mask)
                                                       : (cur_word & ~bit_mask);
    assign scan_word = (kind_reg == abe_pkg::KIND_FIND_SET) ? cur_word : ~cur_word;
    assign scan_low  = scan_word & (~scan_word + abe_pkg::word_t'(1));

    always_comb begin
        scan_pos = '0;
        for (int b = 0; b < abe_pkg::WORD_BITS; b++) begin
            if (scan_low[b]) begin
                scan_pos = scan_pos | abe_pkg::BIT_SHIFT'(b);
            end
        end
    end

    assign ram_re = (state_reg == S_LOOK);
    assign ram_we = (state_reg == S_READ) && !oor_reg
                 && ((kind_reg == abe_pkg::KIND_SET) || (kind_reg == abe_pkg::KIND_CLEAR));

    always_comb begin
        fcmd           = '0;
        fcmd.find_set  = (kind_reg == abe_pkg::KIND_FIND_SET);
        fcmd.set_all   = (state_reg == S_LOOK) && (kind_reg == abe_pkg::KIND_SET_ALL);
        fcmd.clear_all = (state_reg == S_LOOK) && (kind_reg == abe_pkg::KIND_CLEAR_ALL);
        fcmd.word_wr   = ram_we;
        fcmd.addr      = addr_reg;
        fcmd.full      = &new_word;
        fcmd.empty     = ~|new_word;
    end

    abe_word_ram #(
        .DATA_W (abe_pkg::WORD_BITS),
        .ADDR_W (abe_pkg::WORD_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (new_word),
        .rd_en   (ram_re),
        .rd_addr (addr_next),
        .rd_data (ram_q)
    );

    abe_flags u_flags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_live  (n_live),
        .rd_addr (addr_reg),
        .cmd     (fcmd),
        .stat    (fstat)
    );

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        found_next   = found_reg;
        oor_next     = oor_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    idx_next   = s_data.bit_index;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                addr_next  = is_bit_op ? abe_pkg::waddr_t'(word_full) : fstat.hit_addr;
                found_next = is_find && fstat.hit;
                oor_next   = is_bit_op && !in_range;
                state_next = S_READ;
            end
            S_READ: begin
                res_next              = '0;
                res_next.out_of_range = oor_reg;
                res_next.bit_value    = (kind_reg == abe_pkg::KIND_TEST) && !oor_reg
                                     && cur_word[pos];
                res_next.found        = found_reg;
                res_next.found_index  = found_reg
                                     ? abe_pkg::INDEX_W'({addr_reg, scan_pos}) : '0;
                state_next            = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next           = res_reg;
                    m_data_next.all_clear = fstat.all_clear;
                    m_data_next.all_set   = fstat.all_set;
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= abe_pkg::ACTIVE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
        end
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        found_reg  <= found_next;
        oor_reg    <= oor_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("engine accepted a transfer while an operation was in flight");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_READ) && !oor_reg)
        else $error("word write outside the modify step or out of range");

    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> !m_data.out_of_range && !m_data.bit_value)
        else $error("find result carries bit-access fields");

endmodule

### tb/bitmap_op_checker.sv
// Scoreboard for allocation_bitmap_engine_core: tracks the bitmap and active word count,
// predicts each operation's result and compares it with the result channel.
// Depends on abe_pkg.
module bitmap_op_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  abe_pkg::abe_in_t          s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  abe_pkg::abe_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [abe_pkg::CFG_W-1:0] cfg_wr_data,
    output int                        mismatches,
    output int                        pending,
    output int                        results_seen
);

    abe_pkg::word_t            model_words [abe_pkg::WORD_COUNT];
    logic [abe_pkg::CFG_W-1:0] model_active;
    abe_pkg::abe_out_t         due_results [$];
    abe_pkg::abe_out_t         want;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH result %0d %s: got %0d, want %0d",
                 results_seen, what, got, exp_val);
        mismatches++;
    endtask

    function automatic abe_pkg::abe_out_t apply_op(input abe_pkg::abe_in_t op);
        abe_pkg::abe_out_t r;
        int       live;
        int       wrd;
        int       pos;
        logic     got;
        logic     want_bit;
        r    = '0;
        got  = 1'b0;
        live = (model_active > abe_pkg::WORD_COUNT) ? abe_pkg::WORD_COUNT
                                                    : int'(model_active);
        wrd  = int'(op.bit_index) / abe_pkg::WORD_BITS;
        pos  = int'(op.bit_index) % abe_pkg::WORD_BITS;
        want_bit = (op.kind == abe_pkg::KIND_FIND_SET);
        case (op.kind)
            abe_pkg::KIND_TEST, abe_pkg::KIND_SET, abe_pkg::KIND_CLEAR: begin
                if (wrd >= live) begin
                    r.out_of_range = 1'b1;
                end else if (op.kind == abe_pkg::KIND_TEST) begin
                    r.bit_value = model_words[wrd][pos];
                end else if (op.kind == abe_pkg::KIND_SET) begin
                    model_words[wrd][pos] = 1'b1;
                end else begin
                    model_words[wrd][pos] = 1'b0;
                end
            end
            abe_pkg::KIND_SET_ALL: begin
                for (int w = 0; w < live; w++) model_words[w] = '1;
            end
            abe_pkg::KIND_CLEAR_ALL: begin
                for (int w = 0; w < live; w++) model_words[w] = '0;
            end
            abe_pkg::KIND_FIND_CLEAR, abe_pkg::KIND_FIND_SET: begin
                for (int w = 0; w < live; w++) begin
                    for (int b = 0; b < abe_pkg::WORD_BITS; b++) begin
                        if (!got && model_words[w][b] == want_bit) begin
                            got = 1'b1;
                            r.found_index = abe_pkg::INDEX_W'(w * abe_pkg::WORD_BITS + b);
                        end
                    end
                end
                r.found = got;
            end
            default: begin
            end
        endcase
        r.all_clear = 1'b1;
        r.all_set   = 1'b1;
        for (int w = 0; w < live; w++) begin
            if (model_words[w] != '0) r.all_clear = 1'b0;
            if (model_words[w] != '1) r.all_set = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (model_words[w]) model_words[w] = '0;
            model_active = abe_pkg::ACTIVE_RESET;
            due_results.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("transfer with no result due", int'(m_data), 0);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.bit_value !== want.bit_value)
                        report_mismatch("bit_value", m_data.bit_value, want.bit_value);
                    if (m_data.found !== want.found)
                        report_mismatch("found", m_data.found, want.found);
                    if (m_data.found_index !== want.found_index)
                        report_mismatch("found_index", m_data.found_index, want.found_index);
                    if (m_data.all_clear !== want.all_clear)
                        report_mismatch("all_clear", m_data.all_clear, want.all_clear);
                    if (m_data.all_set !== want.all_set)
                        report_mismatch("all_set", m_data.all_set, want.all_set);
                    if (m_data.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", m_data.out_of_range,
                                        want.out_of_range);
                end
                results_seen++;
            end
            if (s_valid && s_ready) due_results.push_back(apply_op(s_data));
            if (cfg_wr_en) model_active = cfg_wr_data;
        end
        pending = due_results.size();
    end

endmodule

### tb/testbench.sv
// Top of the allocation_bitmap_engine_core bench: clock, reset, operation stimulus,
// random result-side stalls, watchdog and verdict. Depends on abe_pkg,
// allocation_bitmap_engine_core and bitmap_op_checker.
module testbench;

    localparam logic [abe_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 12;
    localparam int PHASE_ACTIVE [PHASES] = '{64, 1, 2, 8, 0, 127, 33, -1, 64, -1, 16, 64};

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    abe_pkg::abe_in_t          s_data;
    logic                      m_valid;
    logic                      m_ready = 1'b1;
    abe_pkg::abe_out_t         m_data;
    logic                      cfg_wr_en;
    logic [abe_pkg::CFG_W-1:0] cfg_wr_data;

    int mismatches;
    int pending;
    int results_seen;
    int ops_sent     = 0;
    int settings     = 0;
    int live_words   = abe_pkg::WORD_COUNT;
    int tx_gap_rate  = 4;
    int rx_stall_rate = 4;
    int stall_left   = 0;
    int idle_cycles  = 0;
    int set_bias     = 5;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    allocation_bitmap_engine_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bitmap_op_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stall_rate != 0 && $urandom_range(1, rx_stall_rate) == 1) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(input logic [abe_pkg::KIND_W-1:0] k, input int idx);
        if (tx_gap_rate != 0 && $urandom_range(1, tx_gap_rate) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{kind: k, bit_index: idx[abe_pkg::INDEX_W-1:0]};
        do @(posedge aclk); while (!s_ready);
        ops_sent++;
    endtask

    // hold off until every transfer has its result
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_active(input int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[abe_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        live_words = (value > abe_pkg::WORD_COUNT) ? abe_pkg::WORD_COUNT : value;
        settings++;
    endtask

    task automatic random_op();
        int                         r;
        int                         idx;
        int                         span;
        logic [abe_pkg::KIND_W-1:0] k;
        r    = $urandom_range(0, 99);
        span = live_words * abe_pkg::WORD_BITS;
        if (span > 0 && $urandom_range(0, 9) != 0) idx = $urandom_range(0, span - 1);
        else idx = $urandom_range(0, (1 << abe_pkg::INDEX_W) - 1);
        if (r < 38) begin
            k = ($urandom_range(0, 9) < set_bias) ? abe_pkg::KIND_SET : abe_pkg::KIND_CLEAR;
        end
        else if (r < 56) k = abe_pkg::KIND_TEST;
        else if (r < 72) k = abe_pkg::KIND_FIND_CLEAR;
        else if (r < 88) k = abe_pkg::KIND_FIND_SET;
        else if (r < 91) k = abe_pkg::KIND_SET_ALL;
        else if (r < 94) k = abe_pkg::KIND_CLEAR_ALL;
        else if (r < 97) k = KIND_UNUSED;
        else k = abe_pkg::KIND_W'($urandom_range(0, 7));
        send_op(k, idx);
    endtask

    initial begin
        int target;
        int count;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(abe_pkg::KIND_FIND_SET, 0);
        send_op(abe_pkg::KIND_FIND_CLEAR, 0);
        send_op(abe_pkg::KIND_SET, 0);
        send_op(abe_pkg::KIND_SET, 511);
        send_op(abe_pkg::KIND_TEST, 511);
        send_op(abe_pkg::KIND_FIND_SET, 0);
        send_op(abe_pkg::KIND_CLEAR, 0);
        send_op(abe_pkg::KIND_FIND_SET, 0);
        send_op(abe_pkg::KIND_SET_ALL, 0);
        send_op(abe_pkg::KIND_FIND_CLEAR, 0);
        send_op(abe_pkg::KIND_CLEAR, 300);
        send_op(abe_pkg::KIND_FIND_CLEAR, 0);
        send_op(KIND_UNUSED, 511);
        send_op(abe_pkg::KIND_CLEAR_ALL, 0);
        send_op(abe_pkg::KIND_SET, 200);
        write_active(4);
        send_op(abe_pkg::KIND_SET, 31);
        send_op(abe_pkg::KIND_TEST, 32);
        send_op(abe_pkg::KIND_SET, 40);
        send_op(abe_pkg::KIND_SET_ALL, 0);
        send_op(abe_pkg::KIND_FIND_CLEAR, 0);
        write_active(64);
        send_op(abe_pkg::KIND_TEST, 200);
        send_op(abe_pkg::KIND_FIND_CLEAR, 0);
        write_active(0);
        send_op(abe_pkg::KIND_TEST, 0);
        send_op(abe_pkg::KIND_FIND_SET, 0);
        send_op(abe_pkg::KIND_SET_ALL, 0);
        write_active(127);
        send_op(abe_pkg::KIND_FIND_SET, 0);
        write_active(1);
        send_op(abe_pkg::KIND_CLEAR, 8);

        for (int p = 0; p < PHASES; p++) begin
            target = (PHASE_ACTIVE[p] < 0) ? $urandom_range(1, 127) : PHASE_ACTIVE[p];
            write_active(target);
            count    = (target == 0) ? 40 : PHASE_ITEMS;
            set_bias = $urandom_range(2, 8);
            if (p == PHASES - 1) begin
                tx_gap_rate   = 0;
                rx_stall_rate <= 0;
            end else begin
                tx_gap_rate   = $urandom_range(0, 2) * 4;
                rx_stall_rate <= $urandom_range(0, 2) * 4;
            end
            for (int i = 0; i < count; i++) begin
                if (p != PHASES - 1 && $urandom_range(0, 99) == 0) settle();
                random_op();
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("Ran %0d operations over %0d active-count settings; %0d results checked.",
                 ops_sent, settings, results_seen);
        $display("Settings spanned empty, single-word, partial, full and oversized maps.");
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
